// ===== sv/drt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants of the dynamic rank table
// Field widths, the reset count of positions in use, and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package drt_pkg;

   localparam int unsigned POS_W   = 14;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned RANK_W  = 14;
   localparam int unsigned COUNT_W = 14;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 14'd8192;

   typedef struct packed {
      logic load_req;   // latch the request fields
      logic mem_clear;  // clear one store entry, advance the clear pointer
      logic mem_write;  // write the latched value (gated by position check)
      logic read_own;   // read the entry at the latched position
      logic key_load;   // take own value as key, start rank and scan
      logic scan_read;  // read the next scan entry
   } drt_cmd_type;

   typedef struct packed {
      logic req_is_write; // mode of the request on the inputs
      logic req_pos_ok;   // position on the inputs is in range
      logic clear_last;   // clear pointer at the last entry
      logic scan_last;    // scan pointer at the last live entry
   } drt_status_type;

endpackage : drt_pkg
`default_nettype wire

// ===== sv/dynamic_rank_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dynamic_rank_table: table of signed values with rank queries
// A write stores a value at one position; a query returns the one-based rank
// of an entry by (value, position), counted by scanning the store.
// ----------------------------------------------------------------------------
// Write: busy during the write step, no result; a new request is taken only after it.
// Query: result shown after the own read, key load, scan and drain steps, one store read a
//    cycle over all live entries through the single read port; invalid position: 0.
// A result is shown for one cycle on rsp_valid; the receiver cannot stall.
// Reset: busy stays high while the store is cleared, one entry a cycle over all
//    TABLE_DEPTH entries; csr writes are taken during that time.
// ----------------------------------------------------------------------------
module dynamic_rank_table #(
   parameter int unsigned TABLE_DEPTH = 8192
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_we,
   input  wire        [drt_pkg::COUNT_W-1:0]    csr_wdata,
   input  wire                                  start,
   output logic                                 busy,
   input  wire                                  req_mode,
   input  wire        [drt_pkg::POS_W-1:0]      req_position,
   input  wire signed [drt_pkg::VALUE_W-1:0]    req_new_value,
   output logic                                 rsp_valid,
   output logic       [drt_pkg::RANK_W-1:0]     rsp_rank
);
   import drt_pkg::*;

   drt_cmd_type    cmd;
   drt_status_type status;

   drt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   drt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_mode      (req_mode),
      .req_position  (req_position),
      .req_new_value (req_new_value),
      .rsp_rank      (rsp_rank),
      .cmd           (cmd),
      .status        (status)
   );

endmodule : dynamic_rank_table
`default_nettype wire

// ===== sv/drt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drt_ctrl: controller of the dynamic rank table
// Sequences the clearing pass after reset, writes, and the scan of a rank
// query, and raises the result strobe.
// ----------------------------------------------------------------------------
module drt_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   output logic                     rsp_valid,
   input  drt_pkg::drt_status_type  status,
   output drt_pkg::drt_cmd_type     cmd
);
   import drt_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_WRITE = 3'd2;
   localparam logic [2:0] ST_FETCH = 3'd3;
   localparam logic [2:0] ST_KEY   = 3'd4;
   localparam logic [2:0] ST_SCAN  = 3'd5;
   localparam logic [2:0] ST_DRAIN = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign accept    = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               if (status.req_is_write) begin
                  state_in = ST_WRITE;
               end else if (status.req_pos_ok) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_DONE; // rank 0 already loaded
               end
            end
         end
         ST_CLEAR: begin
            cmd.mem_clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_FETCH: begin
            cmd.read_own = 1'b1;
            state_in     = ST_KEY;
         end
         ST_KEY: begin
            cmd.key_load = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE; // last compare lands here
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLEAR))
      else $error("store clearing pass does not follow reset");

   a_done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (state_ff == ST_IDLE))
      else $error("result strobe longer than one cycle");

   a_write_path: assert property (@(posedge clock) disable iff (reset)
      (accept && status.req_is_write) |=> (state_ff == ST_WRITE && !rsp_valid))
      else $error("write request did not go to the write step");

   a_query_scans: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KEY) |=> (state_ff == ST_SCAN && $past(cmd.key_load)))
      else $error("query key load not followed by scan");

endmodule : drt_ctrl
`default_nettype wire

// ===== sv/drt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drt_datapath: value store and rank counter of the dynamic rank table
// Holds the entry count register, the value memory with its registered read,
// the request latch, the scan pointer and the compare-and-count stage.
// ----------------------------------------------------------------------------
module drt_datapath #(
   parameter int unsigned TABLE_DEPTH = 8192
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_we,
   input  wire        [drt_pkg::COUNT_W-1:0]    csr_wdata,
   input  wire                                  req_mode,
   input  wire        [drt_pkg::POS_W-1:0]      req_position,
   input  wire signed [drt_pkg::VALUE_W-1:0]    req_new_value,
   output logic       [drt_pkg::RANK_W-1:0]     rsp_rank,
   input  drt_pkg::drt_cmd_type                 cmd,
   output drt_pkg::drt_status_type              status
);
   import drt_pkg::*;

   localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned DW   = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned CW   = (DW > POS_W) ? DW : POS_W;
   localparam logic [CW-1:0] DEPTH_CW = CW'(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

   logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];

   logic [COUNT_W-1:0]        count_ff;
   logic [POS_W-1:0]          pos_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic                      pos_ok_ff;
   logic signed [VALUE_W-1:0] rd_ff;
   logic signed [VALUE_W-1:0] key_ff;
   logic [AW-1:0]             clr_idx_ff;
   logic [AW-1:0]             scan_idx_ff;
   logic [AW-1:0]             cmp_idx_ff;
   logic                      cmp_vld_ff;
   logic [CW-1:0]             rank_ff;

   logic [CW-1:0]             live;
   logic [CW-1:0]             req_pos_cw;
   logic [POS_W-1:0]          pos_m1;
   logic [CW-1:0]             pos_m1_cw;
   logic [AW-1:0]             own_addr;
   logic                      we;
   logic [AW-1:0]             wa;
   logic signed [VALUE_W-1:0] wd;
   logic                      re;
   logic [AW-1:0]             ra;
   logic                      before_me;

   // an oversized count is taken as the store depth
   always_comb begin
      live = CW'(count_ff);
      if (live > DEPTH_CW) begin
         live = DEPTH_CW;
      end
   end

   assign req_pos_cw = CW'(req_position);
   assign pos_m1     = pos_ff - 1'b1;
   assign pos_m1_cw  = CW'(pos_m1);
   assign own_addr   = pos_m1_cw[AW-1:0];

   assign status.req_is_write = !req_mode;
   assign status.req_pos_ok   = (req_position != '0) && (req_pos_cw <= live);
   assign status.clear_last   = (clr_idx_ff == LAST_ADDR);
   assign status.scan_last    = (CW'(scan_idx_ff) == (live - 1'b1));

   always_comb begin
      we = 1'b0;
      wa = own_addr;
      wd = val_ff;
      if (cmd.mem_clear) begin
         we = 1'b1;
         wa = clr_idx_ff;
         wd = '0;
      end else if (cmd.mem_write && pos_ok_ff) begin
         we = 1'b1;
      end
   end

   assign re = cmd.read_own || cmd.scan_read;
   assign ra = cmd.scan_read ? scan_idx_ff : own_addr;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_ff <= mem[ra];
      end
   end

   // order by (value, position): ties go to the lower position
   assign before_me = (rd_ff < key_ff) || ((rd_ff == key_ff) && (cmp_idx_ff < own_addr));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= COUNT_RESET;
         clr_idx_ff  <= '0;
         cmp_vld_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
         if (cmd.mem_clear) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         cmp_vld_ff <= cmd.scan_read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         pos_ff    <= req_position;
         val_ff    <= req_new_value;
         pos_ok_ff <= status.req_pos_ok;
         rank_ff   <= '0;
      end else if (cmd.key_load) begin
         rank_ff <= CW'(1);
      end else if (cmp_vld_ff && before_me) begin
         rank_ff <= rank_ff + 1'b1;
      end
      if (cmd.key_load) begin
         key_ff      <= rd_ff;
         scan_idx_ff <= '0;
      end else if (cmd.scan_read) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      cmp_idx_ff <= scan_idx_ff;
   end

   assign rsp_rank = rank_ff[RANK_W-1:0];

   a_one_port_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.mem_clear, cmd.mem_write, cmd.read_own, cmd.scan_read}))
      else $error("conflicting store operations in one cycle");

   a_cmp_follows_read: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> $past(cmd.scan_read))
      else $error("compare without a scan read");

   a_rank_starts_one: assert property (@(posedge clock) disable iff (reset)
      cmd.key_load |=> (rank_ff == CW'(1)))
      else $error("rank count did not start at one");

endmodule : drt_datapath
`default_nettype wire
